### rtl/core/bce_pkg.sv
// shared types, constants and codes for the breakpoint curve evaluator
// no dependencies; imported by every module of the block
package bce_pkg;

    // table size, derived index width and count width
    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = 7;

    // operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_EVAL   = 2'd3;

    // status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;

    // curve codes
    localparam logic [1:0] CRV_STEP   = 2'd0;
    localparam logic [1:0] CRV_LIN    = 2'd1;
    localparam logic [1:0] CRV_BEZ    = 2'd2;
    localparam logic [1:0] CRV_SCURVE = 2'd3;

    // value returned for an empty table
    localparam logic [15:0] LEVEL_HALF = 16'd32768;

    typedef struct packed {
        logic [1:0]         op;
        logic [31:0]        beat;
        logic [15:0]        level;
        logic [1:0]         curve;
        logic               has_handles;
        logic signed [15:0] out_tangent;
        logic signed [15:0] in_tangent;
        logic [5:0]         index;
    } t_in_req;

    typedef struct packed {
        logic [15:0]      result_level;
        logic [1:0]       status;
        logic [CNT_W-1:0] point_count;
    } t_out_req;

    typedef struct packed {
        logic signed [15:0] in_tangent;
        logic signed [15:0] out_tangent;
        logic               has_handles;
        logic [1:0]         curve;
    } t_shape;

    typedef struct packed {
        logic [31:0] beat;
        logic [15:0] level;
        t_shape      shape;
    } t_entry;

    // segment handed to the interpolator
    typedef struct packed {
        logic [31:0] d;
        logic [31:0] span;
        logic [15:0] v1;
        logic [15:0] v2;
        t_shape      shape;
    } t_interp_req;

endpackage

### rtl/core/bce_interp.sv
// segment interpolator: radix-2 divider for t, then a shared multiplier
// stepped through linear, s-curve and bezier sequences; uses bce_pkg
module bce_interp
    import bce_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_interp_req i_req,
    output logic        o_done,
    output logic [15:0] o_result
);

    typedef enum logic [18:0] {
        I_IDLE = 19'b0000000000000000001,
        I_DIV  = 19'b0000000000000000010,
        I_SQ   = 19'b0000000000000000100,
        I_SC   = 19'b0000000000000001000,
        I_L0   = 19'b0000000000000010000,
        I_L1   = 19'b0000000000000100000,
        I_UU   = 19'b0000000000001000000,
        I_UT   = 19'b0000000000010000000,
        I_TT   = 19'b0000000000100000000,
        I_W0   = 19'b0000000001000000000,
        I_W1   = 19'b0000000010000000000,
        I_W2   = 19'b0000000100000000000,
        I_W3   = 19'b0000001000000000000,
        I_P2   = 19'b0000010000000000000,
        I_A0   = 19'b0000100000000000000,
        I_A1   = 19'b0001000000000000000,
        I_A2   = 19'b0010000000000000000,
        I_A3   = 19'b0100000000000000000,
        I_FIN  = 19'b1000000000000000000
    } t_istate;

    t_istate            r_state, n_state;
    t_interp_req        r_req, n_req;
    logic [32:0]        r_rem, n_rem;
    logic [16:0]        r_quot, n_quot;
    logic [4:0]         r_cnt, n_cnt;
    logic               r_first, n_first;
    logic               r_bez, n_bez;
    logic [16:0]        r_t, n_t;
    logic [33:0]        r_uu, n_uu, r_ut, n_ut, r_tt, n_tt;
    logic [16:0]        r_w0, n_w0, r_w1, n_w1, r_w2, n_w2, r_w3, n_w3;
    logic signed [35:0] r_p2, n_p2;
    logic signed [55:0] r_acc, n_acc;

    // shared multiplier
    logic signed [35:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [53:0] prod;
    logic signed [55:0] pe, pe3, sc_s, lin_r, bez_r;
    logic [16:0]        u;
    logic [32:0]        cand;
    logic               ge;
    logic signed [16:0] dv;
    logic signed [18:0] sum1;
    logic signed [17:0] cit;

    assign u    = 17'd65536 - r_t;
    assign prod = mul_a * mul_b;
    assign pe   = 56'(prod);
    assign pe3  = pe + (pe <<< 1);

    // bezier control point terms
    assign dv   = $signed({1'b0, r_req.v2}) - $signed({1'b0, r_req.v1});
    assign sum1 = $signed({3'b000, r_req.v1})
                + ($signed({{3{r_req.shape.out_tangent[15]}}, r_req.shape.out_tangent}) <<< 1);
    assign cit  = 18'sd32768 - 18'(r_req.shape.in_tangent);

    // one quotient bit per cycle
    assign cand = r_first ? r_rem : {r_rem[31:0], 1'b0};
    assign ge   = cand >= {1'b0, r_req.span};

    // operand selection per step
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            I_SQ, I_TT: begin mul_a = 36'(r_t); mul_b = 18'(r_t); end
            I_SC: begin
                mul_a = 36'(18'd196608 - {r_t, 1'b0});
                mul_b = 18'((r_tt + 34'd32768) >> 16);
            end
            I_L0: begin mul_a = 36'(r_req.v1); mul_b = 18'(u); end
            I_L1: begin mul_a = 36'(r_req.v2); mul_b = 18'(r_t); end
            I_UU: begin mul_a = 36'(u); mul_b = 18'(u); end
            I_UT: begin mul_a = 36'(u); mul_b = 18'(r_t); end
            I_W0: begin mul_a = 36'(r_uu); mul_b = 18'(u); end
            I_W1: begin mul_a = 36'(r_uu); mul_b = 18'(r_t); end
            I_W2: begin mul_a = 36'(r_ut); mul_b = 18'(r_t); end
            I_W3: begin mul_a = 36'(r_tt); mul_b = 18'(r_t); end
            I_P2: begin mul_a = 36'(dv); mul_b = cit; end
            I_A0: begin mul_a = 36'({r_req.v1, 15'b0}); mul_b = 18'(r_w0); end
            I_A1: begin mul_a = 36'(sum1) <<< 15; mul_b = 18'(r_w1); end
            I_A2: begin mul_a = r_p2; mul_b = 18'(r_w2); end
            I_A3: begin mul_a = 36'({r_req.v2, 15'b0}); mul_b = 18'(r_w3); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign sc_s = (pe + 56'sd32768) >>> 16;

    // sequencer
    always_comb begin
        n_state = r_state;
        n_req   = r_req;
        n_rem   = r_rem;
        n_quot  = r_quot;
        n_cnt   = r_cnt;
        n_first = r_first;
        n_bez   = r_bez;
        n_t     = r_t;
        n_uu    = r_uu;
        n_ut    = r_ut;
        n_tt    = r_tt;
        n_w0    = r_w0;
        n_w1    = r_w1;
        n_w2    = r_w2;
        n_w3    = r_w3;
        n_p2    = r_p2;
        n_acc   = r_acc;
        unique case (r_state)
            I_IDLE: begin
                if (i_start) begin
                    n_req   = i_req;
                    n_rem   = {1'b0, i_req.d};
                    n_quot  = '0;
                    n_cnt   = 5'd16;
                    n_first = 1'b1;
                    n_bez   = (i_req.shape.curve == CRV_BEZ) && i_req.shape.has_handles;
                    n_state = I_DIV;
                end
            end
            I_DIV: begin
                n_first = 1'b0;
                n_rem   = ge ? (cand - {1'b0, r_req.span}) : cand;
                n_quot  = {r_quot[15:0], ge};
                n_cnt   = r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    n_t = (n_quot > 17'd65536) ? 17'd65536 : n_quot;
                    priority if (r_req.shape.curve == CRV_SCURVE) n_state = I_SQ;
                    else if (r_bez) n_state = I_UU;
                    else n_state = I_L0;
                end
            end
            I_SQ: begin n_tt = prod[33:0]; n_state = I_SC; end
            I_SC: begin
                n_t     = (sc_s > 56'sd65536) ? 17'd65536 : sc_s[16:0];
                n_state = I_L0;
            end
            I_L0: begin n_acc = pe; n_state = I_L1; end
            I_L1: begin n_acc = r_acc + pe; n_state = I_FIN; end
            I_UU: begin n_uu = prod[33:0]; n_state = I_UT; end
            I_UT: begin n_ut = prod[33:0]; n_state = I_TT; end
            I_TT: begin n_tt = prod[33:0]; n_state = I_W0; end
            I_W0: begin n_w0 = 17'((pe + 56'sd2147483648) >>> 32); n_state = I_W1; end
            I_W1: begin n_w1 = 17'((pe3 + 56'sd2147483648) >>> 32); n_state = I_W2; end
            I_W2: begin n_w2 = 17'((pe3 + 56'sd2147483648) >>> 32); n_state = I_W3; end
            I_W3: begin n_w3 = 17'((pe + 56'sd2147483648) >>> 32); n_state = I_P2; end
            I_P2: begin
                n_p2    = $signed(36'({r_req.v2, 15'b0})) - 36'(prod);
                n_state = I_A0;
            end
            I_A0: begin n_acc = pe; n_state = I_A1; end
            I_A1: begin n_acc = r_acc + pe; n_state = I_A2; end
            I_A2: begin n_acc = r_acc + pe; n_state = I_A3; end
            I_A3: begin n_acc = r_acc + pe; n_state = I_FIN; end
            I_FIN: n_state = I_IDLE;
            default: n_state = I_IDLE;
        endcase
    end

    // rounding and saturation of the accumulated sum
    assign lin_r = (r_acc + 56'sd32768) >>> 16;
    assign bez_r = (r_acc + 56'sd1073741824) >>> 31;

    always_comb begin
        if (r_bez) begin
            priority if (r_acc < 0) o_result = 16'd0;
            else if (bez_r > 56'sd65535) o_result = 16'hFFFF;
            else o_result = bez_r[15:0];
        end else begin
            if (lin_r > 56'sd65535) o_result = 16'hFFFF;
            else o_result = lin_r[15:0];
        end
    end

    assign o_done = (r_state == I_FIN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= I_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req   <= n_req;
        r_rem   <= n_rem;
        r_quot  <= n_quot;
        r_cnt   <= n_cnt;
        r_first <= n_first;
        r_bez   <= n_bez;
        r_t     <= n_t;
        r_uu    <= n_uu;
        r_ut    <= n_ut;
        r_tt    <= n_tt;
        r_w0    <= n_w0;
        r_w1    <= n_w1;
        r_w2    <= n_w2;
        r_w3    <= n_w3;
        r_p2    <= n_p2;
        r_acc   <= n_acc;
    end

endmodule

### rtl/core/breakpoint_curve_evaluator_unit.sv
// from accept to result valid: clear and rejected requests go straight to the output stage;
// evaluate probes the search with a read then a compare, and may then run the divider and
// up to 12 multiplier steps; one request at a time, the table memory (one read port, one
// write port) and shared divider/multiplier set the pace; the next request is taken while
// a result waits in the output register; reset empties the table at once, no sweep
// top level: sorted point table in one memory, request sequencer, output register; uses bce_pkg and bce_interp
module breakpoint_curve_evaluator_unit
    import bce_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_req  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_out_req o_out_data
);

    typedef enum logic [12:0] {
        S_IDLE    = 13'b0000000000001,
        S_INS_RD  = 13'b0000000000010,
        S_INS_CMP = 13'b0000000000100,
        S_INS_PUT = 13'b0000000001000,
        S_RM_RD   = 13'b0000000010000,
        S_RM_WR   = 13'b0000000100000,
        S_SR_RD   = 13'b0000001000000,
        S_SR_CMP  = 13'b0000010000000,
        S_EV_RD1  = 13'b0000100000000,
        S_EV_RD2  = 13'b0001000000000,
        S_EV_CHK  = 13'b0010000000000,
        S_EV_MATH = 13'b0100000000000,
        S_DONE    = 13'b1000000000000
    } t_state;

    t_state           r_state, n_state;
    t_in_req          r_req, n_req;
    logic [CNT_W-1:0] r_held, n_held;
    logic [CNT_W-1:0] r_pos, n_pos;
    logic [CNT_W-1:0] r_hi, n_hi;
    logic [IDX_W-1:0] r_mid, n_mid;
    t_entry           r_e1, n_e1;
    t_out_req         r_res, n_res;
    logic             r_out_valid, n_out_valid;
    t_out_req         r_out, n_out;

    // point table
    t_entry           r_mem [MAX_POINTS];
    t_entry           r_rd;
    logic             we;
    logic [IDX_W-1:0] wa, ra;
    t_entry           wd;

    logic [CNT_W-1:0] pos_m1, pos_p1;
    logic [CNT_W:0]   mid_sum;
    logic [CNT_W-1:0] mid_full;

    t_interp_req      ip_req;
    logic             ip_start, ip_done;
    logic [15:0]      ip_result;

    assign pos_m1   = r_pos - CNT_W'(1);
    assign pos_p1   = r_pos + CNT_W'(1);
    assign mid_sum  = {1'b0, r_pos} + {1'b0, r_hi};
    assign mid_full = mid_sum[CNT_W:1];

    assign ip_req.d     = r_req.beat - r_e1.beat;
    assign ip_req.span  = r_rd.beat - r_e1.beat;
    assign ip_req.v1    = r_e1.level;
    assign ip_req.v2    = r_rd.level;
    assign ip_req.shape = r_e1.shape;

    bce_interp u_interp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (ip_start),
        .i_req    (ip_req),
        .o_done   (ip_done),
        .o_result (ip_result)
    );

    // request sequencer
    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_held      = r_held;
        n_pos       = r_pos;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_e1        = r_e1;
        n_res       = r_res;
        n_out_valid = r_out_valid & ~i_out_ready;
        n_out       = r_out;
        we          = 1'b0;
        wa          = r_pos[IDX_W-1:0];
        wd          = r_rd;
        ra          = '0;
        ip_start    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req = i_in_data;
                    n_res = '0;
                    unique case (i_in_data.op)
                        OP_INSERT: begin
                            n_pos = r_held;
                            priority if (r_held >= CNT_W'(MAX_POINTS)) begin
                                n_res.status = STAT_FULL;
                                n_state      = S_DONE;
                            end else if (r_held == '0) begin
                                n_state = S_INS_PUT;
                            end else begin
                                n_state = S_INS_RD;
                            end
                        end
                        OP_REMOVE: begin
                            n_pos = CNT_W'(i_in_data.index);
                            if (CNT_W'(i_in_data.index) >= r_held) begin
                                n_res.status = STAT_RANGE;
                                n_state      = S_DONE;
                            end else begin
                                n_state = S_RM_RD;
                            end
                        end
                        OP_CLEAR: begin
                            n_held  = '0;
                            n_state = S_DONE;
                        end
                        OP_EVAL: begin
                            n_pos = '0;
                            n_hi  = r_held;
                            if (r_held == '0) begin
                                n_res.result_level = LEVEL_HALF;
                                n_state            = S_DONE;
                            end else begin
                                n_state = S_SR_RD;
                            end
                        end
                    endcase
                end
            end
            // shift larger points up one slot, from the top down
            S_INS_RD: begin
                ra      = pos_m1[IDX_W-1:0];
                n_state = S_INS_CMP;
            end
            S_INS_CMP: begin
                if (r_rd.beat > r_req.beat) begin
                    we    = 1'b1;
                    wd    = r_rd;
                    n_pos = pos_m1;
                    n_state = (pos_m1 == '0) ? S_INS_PUT : S_INS_RD;
                end else begin
                    n_state = S_INS_PUT;
                end
            end
            S_INS_PUT: begin
                we                   = 1'b1;
                wd.beat              = r_req.beat;
                wd.level             = r_req.level;
                wd.shape.curve       = r_req.curve;
                wd.shape.has_handles = r_req.has_handles;
                wd.shape.out_tangent = r_req.out_tangent;
                wd.shape.in_tangent  = r_req.in_tangent;
                n_held               = r_held + CNT_W'(1);
                n_state              = S_DONE;
            end
            // close the gap, moving each later point down one slot
            S_RM_RD: begin
                ra = pos_p1[IDX_W-1:0];
                if (pos_p1 < r_held) begin
                    n_state = S_RM_WR;
                end else begin
                    n_held  = r_held - CNT_W'(1);
                    n_state = S_DONE;
                end
            end
            S_RM_WR: begin
                we      = 1'b1;
                wd      = r_rd;
                n_pos   = pos_p1;
                n_state = S_RM_RD;
            end
            // binary search for the first point at or after the query
            S_SR_RD: begin
                ra    = mid_full[IDX_W-1:0];
                n_mid = mid_full[IDX_W-1:0];
                n_state = (r_pos < r_hi) ? S_SR_CMP : S_EV_RD1;
            end
            S_SR_CMP: begin
                if (r_rd.beat < r_req.beat) n_pos = CNT_W'(r_mid) + CNT_W'(1);
                else n_hi = CNT_W'(r_mid);
                n_state = S_SR_RD;
            end
            // fetch the left and right points of the segment
            S_EV_RD1: begin
                ra      = pos_m1[IDX_W-1:0];
                n_state = S_EV_RD2;
            end
            S_EV_RD2: begin
                n_e1    = r_rd;
                ra      = r_pos[IDX_W-1:0];
                n_state = S_EV_CHK;
            end
            S_EV_CHK: begin
                priority if (r_pos == '0) begin
                    n_res.result_level = r_rd.level;
                    n_state            = S_DONE;
                end else if (r_pos == r_held) begin
                    n_res.result_level = r_e1.level;
                    n_state            = S_DONE;
                end else if ((r_rd.beat <= r_e1.beat) || (r_req.beat < r_e1.beat) ||
                             (r_e1.shape.curve == CRV_STEP)) begin
                    n_res.result_level = r_e1.level;
                    n_state            = S_DONE;
                end else begin
                    ip_start = 1'b1;
                    n_state  = S_EV_MATH;
                end
            end
            S_EV_MATH: begin
                if (ip_done) begin
                    n_res.result_level = ip_result;
                    n_state            = S_DONE;
                end
            end
            // hand over to the output register once it is free
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid       = 1'b1;
                    n_out             = r_res;
                    n_out.point_count = r_held;
                    n_state           = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // table memory, registered read
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        r_rd <= r_mem[ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_held      <= n_held;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_pos <= n_pos;
        r_hi  <= n_hi;
        r_mid <= n_mid;
        r_e1  <= n_e1;
        r_res <= n_res;
        r_out <= n_out;
    end

endmodule

### rtl/core/bce_checker.sv
// port-level checks for the breakpoint curve evaluator, bound to the top level
// uses bce_pkg
module bce_checker
    import bce_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_valid,
    input logic     i_in_ready,
    input t_in_req  i_in_data,
    input logic     i_out_valid,
    input logic     i_out_ready,
    input t_out_req i_out_data
);

    // a result waiting for the consumer stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result dropped or changed while stalled");

    // one request at a time: no request taken in the cycle after one
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request taken while previous one in flight");

    // count never exceeds table size
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_data.point_count <= CNT_W'(MAX_POINTS))
        else $error("point count out of range");

    // a full report only with a full table
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_data.status == STAT_FULL)
        |-> i_out_data.point_count == CNT_W'(MAX_POINTS))
        else $error("full status with room left");

    // results with an error status carry no level
    a_status_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_data.status != STAT_OK) |-> i_out_data.result_level == '0)
        else $error("error result carries a level");

endmodule

bind breakpoint_curve_evaluator_unit bce_checker u_bce_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_data  (o_out_data)
);

### dv/tb_breakpoint_curve_evaluator_unit.sv
// testbench for the breakpoint curve evaluator: directed table then random requests,
// every result checked against an in-bench model of the sorted point table
// depends on bce_pkg and breakpoint_curve_evaluator_unit
`timescale 1ns / 100ps

module tb_breakpoint_curve_evaluator_unit;
    import bce_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS   = 1100;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_in_valid;
    logic     o_in_ready;
    t_in_req  i_in_data;
    logic     o_out_valid;
    logic     i_out_ready;
    t_out_req o_out_data;

    breakpoint_curve_evaluator_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // model of the point table
    logic [31:0] mdl_beat [MAX_POINTS];
    logic [15:0] mdl_level[MAX_POINTS];
    t_shape      mdl_shape[MAX_POINTS];
    int          mdl_count;

    t_out_req pending_results[$];
    int       error_count;
    int       idle_cycles;

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic logic [15:0] blend_linear(longint v1, longint v2, longint t);
        longint r;
        r = (v1 * (65536 - t) + v2 * t + 32768) >>> 16;
        return (r > 65535) ? 16'hFFFF : r[15:0];
    endfunction

    function automatic logic [15:0] blend_bezier(longint a, longint b, t_shape sh, longint t);
        longint ot, it, p0, p1, p2, p3, u, w0, w1, w2, w3, s, r;
        logic [63:0] uu, tt;
        ot = longint'(sh.out_tangent);
        it = longint'(sh.in_tangent);
        p0 = a * 32768;
        p1 = (a + 2 * ot) * 32768;
        p2 = b * 32768 - (b - a) * (32768 - it);
        p3 = b * 32768;
        u = 65536 - t;
        uu = u;
        tt = t;
        w0 = longint'((uu * uu * uu + 64'h8000_0000) >> 32);
        w1 = longint'((64'd3 * uu * uu * tt + 64'h8000_0000) >> 32);
        w2 = longint'((64'd3 * uu * tt * tt + 64'h8000_0000) >> 32);
        w3 = longint'((tt * tt * tt + 64'h8000_0000) >> 32);
        s = w0 * p0 + w1 * p1 + w2 * p2 + w3 * p3;
        if (s < 0) return 16'd0;
        r = (s + (longint'(1) << 30)) >>> 31;
        return (r > 65535) ? 16'hFFFF : r[15:0];
    endfunction

    function automatic logic [15:0] curve_level_at(logic [31:0] q);
        int lo, hi, mid, k;
        longint v1, v2, t, t2, s;
        logic [31:0] b1, b2;
        t_shape sh;
        if (mdl_count == 0) return LEVEL_HALF;
        lo = 0;
        hi = mdl_count;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (mdl_beat[mid] < q) lo = mid + 1;
            else hi = mid;
        end
        if (lo == 0) return mdl_level[0];
        if (lo >= mdl_count) return mdl_level[mdl_count-1];
        k = lo - 1;
        b1 = mdl_beat[k];
        b2 = mdl_beat[lo];
        v1 = mdl_level[k];
        v2 = mdl_level[lo];
        sh = mdl_shape[k];
        if (b2 <= b1 || q < b1) return v1[15:0];
        t = (longint'(q - b1) << 16) / longint'(b2 - b1);
        if (t > 65536) t = 65536;
        case (sh.curve)
            CRV_STEP: return v1[15:0];
            CRV_LIN:  return blend_linear(v1, v2, t);
            CRV_BEZ:  return sh.has_handles ? blend_bezier(v1, v2, sh, t)
                                            : blend_linear(v1, v2, t);
            default: begin
                t2 = (t * t + 32768) >>> 16;
                s = (t2 * (196608 - 2 * t) + 32768) >>> 16;
                if (s > 65536) s = 65536;
                return blend_linear(v1, v2, s);
            end
        endcase
    endfunction

    // apply one request to the model and return its result
    function automatic t_out_req apply_request(t_in_req r);
        t_out_req o;
        int pos;
        o = '0;
        case (r.op)
            OP_INSERT: begin
                if (mdl_count >= MAX_POINTS) o.status = STAT_FULL;
                else begin
                    pos = mdl_count;
                    while (pos > 0 && mdl_beat[pos-1] > r.beat) begin
                        mdl_beat[pos]  = mdl_beat[pos-1];
                        mdl_level[pos] = mdl_level[pos-1];
                        mdl_shape[pos] = mdl_shape[pos-1];
                        pos--;
                    end
                    mdl_beat[pos]  = r.beat;
                    mdl_level[pos] = r.level;
                    mdl_shape[pos] = '{in_tangent: r.in_tangent, out_tangent: r.out_tangent,
                                       has_handles: r.has_handles, curve: r.curve};
                    mdl_count++;
                end
            end
            OP_REMOVE: begin
                if (int'(r.index) >= mdl_count) o.status = STAT_RANGE;
                else begin
                    for (int i = r.index; i + 1 < mdl_count; i++) begin
                        mdl_beat[i]  = mdl_beat[i+1];
                        mdl_level[i] = mdl_level[i+1];
                        mdl_shape[i] = mdl_shape[i+1];
                    end
                    mdl_count--;
                end
            end
            OP_CLEAR: mdl_count = 0;
            default: o.result_level = curve_level_at(r.beat);
        endcase
        o.point_count = mdl_count[CNT_W-1:0];
        return o;
    endfunction

    function automatic t_in_req make_req(logic [1:0] op, logic [31:0] beat, logic [15:0] level,
                                         logic [1:0] curve, logic hh, logic [15:0] ot,
                                         logic [15:0] it, logic [5:0] idx);
        t_in_req r;
        r.op = op; r.beat = beat; r.level = level; r.curve = curve; r.has_handles = hh;
        r.out_tangent = ot; r.in_tangent = it; r.index = idx;
        return r;
    endfunction

    function automatic t_in_req random_req();
        t_in_req r;
        int pick;
        r = make_req($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom);
        pick = $urandom_range(99);
        if (pick < 35) r.op = OP_INSERT;
        else if (pick < 50) r.op = OP_REMOVE;
        else if (pick < 52) r.op = OP_CLEAR;
        else r.op = OP_EVAL;
        // keep beats in a narrow window most of the time so queries land in segments
        if ($urandom_range(3) != 0) r.beat = 32'h0010_0000 + $urandom_range(32'h0008_0000);
        if (r.op == OP_REMOVE && mdl_count > 0 && $urandom_range(4) != 0)
            r.index = $urandom_range(mdl_count - 1);
        return r;
    endfunction

    // a gap drops the request; back-to-back requests keep valid high
    task automatic random_gap();
        int n;
        n = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(2);
        if ($urandom_range(3) == 0) n = 0;
        if (n > 0) i_in_valid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    // hand one request to the block and record its expected result
    task automatic send_request(t_in_req r, bit typed, t_out_req want);
        t_out_req pred;
        i_in_data  <= r;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pred = apply_request(r);
        if (typed && pred !== want) begin
            report_mismatch("typed row", pred, want);
        end
        pending_results = {pending_results, pred};
        @(negedge i_clk);
    endtask

    // directed rows: op beat level curve handles out_tan in_tan index typed expected
    typedef struct {
        t_in_req  req;
        bit       typed;
        t_out_req want;
    } t_row;

    t_row directed_rows[$];

    task automatic add_row(t_in_req r, bit typed, logic [15:0] lvl, logic [1:0] st, int cnt);
        t_row row;
        row.req = r;
        row.typed = typed;
        row.want = '{result_level: lvl, status: st, point_count: cnt[CNT_W-1:0]};
        directed_rows = {directed_rows, row};
    endtask

    // result checker and idling on the output side
    always @(posedge i_clk) begin
        t_out_req w;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", o_out_data, 0);
            end else begin
                w = pending_results.pop_front();
                if (o_out_data.result_level !== w.result_level)
                    report_mismatch("result_level", o_out_data.result_level, w.result_level);
                if (o_out_data.status !== w.status)
                    report_mismatch("status", o_out_data.status, w.status);
                if (o_out_data.point_count !== w.point_count)
                    report_mismatch("point_count", o_out_data.point_count, w.point_count);
            end
        end
    end

    always @(negedge i_clk) begin
        if ($urandom_range(15) == 0) i_out_ready <= 1'b0;
        else if (!i_out_ready && $urandom_range(3) != 0) i_out_ready <= 1'b0;
        else i_out_ready <= 1'b1;
    end

    // watchdog on cycles with no request moving
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("** breakpoint_curve_evaluator_unit: FAILED **");
            $finish;
        end
    end

    initial begin
        t_in_req r;
        int wait_cycles;
        error_count = 0;
        idle_cycles = 0;
        mdl_count = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_ready = 1'b1;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        add_row(make_req(OP_EVAL, 32'h0, 0, 0, 0, 0, 0, 0), 1, LEVEL_HALF, STAT_OK, 0);
        add_row(make_req(OP_REMOVE, 0, 0, 0, 0, 0, 0, 0), 1, 0, STAT_RANGE, 0);
        add_row(make_req(OP_INSERT, 32'h0001_0000, 16'h1000, CRV_LIN, 0, 0, 0, 0),
                1, 0, STAT_OK, 1);
        add_row(make_req(OP_EVAL, 32'h0, 0, 0, 0, 0, 0, 0), 1, 16'h1000, STAT_OK, 1);
        add_row(make_req(OP_EVAL, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0), 1, 16'h1000, STAT_OK, 1);
        add_row(make_req(OP_INSERT, 32'h0002_0000, 16'hFFFF, CRV_BEZ, 1, 16'h7FFF, 16'h8000,
                         0), 1, 0, STAT_OK, 2);
        add_row(make_req(OP_INSERT, 32'h0003_0000, 16'h0000, CRV_SCURVE, 1, 16'h8000,
                         16'h7FFF, 0), 1, 0, STAT_OK, 3);
        add_row(make_req(OP_INSERT, 32'h0004_0000, 16'h8000, CRV_BEZ, 0, 0, 0, 0),
                1, 0, STAT_OK, 4);
        add_row(make_req(OP_INSERT, 32'h0005_0000, 16'h4000, CRV_STEP, 0, 0, 0, 0),
                1, 0, STAT_OK, 5);
        add_row(make_req(OP_INSERT, 32'h0002_0000, 16'h2222, CRV_LIN, 0, 0, 0, 0),
                1, 0, STAT_OK, 6);
        add_row(make_req(OP_EVAL, 32'h0001_8000, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0);
        add_row(make_req(OP_EVAL, 32'h0002_4000, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0);
        add_row(make_req(OP_EVAL, 32'h0003_4000, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0);
        add_row(make_req(OP_EVAL, 32'h0004_C000, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0);
        add_row(make_req(OP_EVAL, 32'h0005_8000, 0, 0, 0, 0, 0, 0), 1, 16'h4000, STAT_OK, 6);
        add_row(make_req(OP_REMOVE, 0, 0, 0, 0, 0, 0, 6'd63), 1, 0, STAT_RANGE, 6);
        add_row(make_req(OP_REMOVE, 0, 0, 0, 0, 0, 0, 6'd5), 1, 0, STAT_OK, 5);
        add_row(make_req(OP_REMOVE, 0, 0, 0, 0, 0, 0, 6'd0), 1, 0, STAT_OK, 4);
        add_row(make_req(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0), 1, 0, STAT_OK, 0);

        foreach (directed_rows[i]) begin
            send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
            random_gap();
        end

        // fill to capacity once, then overflow
        for (int i = 0; i <= MAX_POINTS; i++) begin
            r = random_req();
            r.op = OP_INSERT;
            send_request(r, 0, '0);
        end
        for (int i = 0; i < 20; i++) begin
            r = random_req();
            r.op = OP_EVAL;
            send_request(r, 0, '0);
        end

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            send_request(random_req(), 0, '0);
            random_gap();
        end
        i_in_valid <= 1'b0;

        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (100) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("** breakpoint_curve_evaluator_unit: PASSED **");
        else
            $display("** breakpoint_curve_evaluator_unit: FAILED **");
        $finish;
    end

endmodule
